/* sv/bcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bcp_pkg;

  // one input transfer: a character or the end-of-text marker
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } bcp_in_t;

  // one result transfer: a decoded byte or the final parse result
  typedef struct packed {
    logic               kind;
    logic [7:0]         byte_value;
    logic [1:0]         status;
    logic signed [31:0] operand_a;
    logic [1:0]         operator_code;
    logic signed [31:0] operand_b;
    logic [6:0]         byte_count;
  } bcp_out_t;

  // parser phases
  typedef enum logic [3:0] {
    PH_LEAD     = 4'd0,
    PH_KEYWORD  = 4'd1,
    PH_KW_END   = 4'd2,
    PH_A_PRE    = 4'd3,
    PH_A_SIGN   = 4'd4,
    PH_A_DIG    = 4'd5,
    PH_OP_WAIT  = 4'd6,
    PH_B_PRE    = 4'd7,
    PH_B_SIGN   = 4'd8,
    PH_B_DIG    = 4'd9,
    PH_COLON    = 4'd10,
    PH_HEX_WAIT = 4'd11,
    PH_HEX_LO   = 4'd12,
    PH_HEX_SEP  = 4'd13,
    PH_STOPPED  = 4'd14
  } bcp_phase_e;

  // final status codes
  typedef enum logic [1:0] {
    ST_CALL     = 2'd0,
    ST_NOT_CALL = 2'd1,
    ST_FORMAT   = 2'd2
  } bcp_status_e;

  // operator codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_RESULT = 1'b1;

  // index of the last keyword character
  localparam logic [2:0] KW_LAST = 3'd5;

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // decoded hex digit with a valid flag
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } bcp_hex_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bcp_hex_t hex_decode(input logic [7:0] c);
    bcp_hex_t h;
    h = '0;
    if ((c >= "0") && (c <= "9")) begin
      h.valid = 1'b1;
      h.value = 4'(c - "0");
    end else if ((c >= "a") && (c <= "f")) begin
      h.valid = 1'b1;
      h.value = 4'(c - "a" + 8'd10);
    end else if ((c >= "A") && (c <= "F")) begin
      h.valid = 1'b1;
      h.value = 4'(c - "A" + 8'd10);
    end
    return h;
  endfunction

  // characters of the keyword /bytes
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = "/";
      3'd1: c = "b";
      3'd2: c = "y";
      3'd3: c = "t";
      3'd4: c = "e";
      3'd5: c = "s";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/bcp_parse_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module bcp_parse_core import bcp_pkg::*; #(
  parameter int CODE_CAPACITY = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire bcp_in_t  item_i,
  output logic          res_valid_o,
  output bcp_out_t      res_o
);

  bcp_phase_e  phase_q, phase_d;
  logic [2:0]  kw_idx_q, kw_idx_d;
  logic [31:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [31:0] first_q, first_d;
  logic [1:0]  op_q, op_d;
  logic [3:0]  hi_q, hi_d;
  logic [6:0]  bytes_q, bytes_d;
  logic [1:0]  err_q, err_d;

  logic [7:0]  c;
  logic [3:0]  digit;
  logic [35:0] mag_ext;
  logic [35:0] acc;
  logic        acc_ovf;
  logic [31:0] signed_val;
  logic [1:0]  final_st;
  bcp_hex_t    hex;
  logic        ws;

  assign c     = item_i.ch;
  assign digit = c[3:0];
  assign ws    = is_ws(c);
  assign hex   = hex_decode(c);

  // multiply-by-ten accumulate with range check against the signed limit
  assign mag_ext    = {4'b0, mag_q};
  assign acc        = (mag_ext << 3) + (mag_ext << 1) + {32'b0, digit};
  assign acc_ovf    = acc > {4'b0, (neg_q ? NEG_LIMIT : POS_LIMIT)};
  assign signed_val = neg_q ? (32'd0 - mag_q) : mag_q;

  // status if the text ended now
  always_comb begin
    case (phase_q)
      PH_LEAD, PH_KEYWORD:     final_st = ST_NOT_CALL;
      PH_HEX_WAIT, PH_HEX_SEP: final_st = (bytes_q != 7'd0) ? ST_CALL : ST_FORMAT;
      PH_STOPPED:              final_st = err_q;
      default:                 final_st = ST_FORMAT;
    endcase
  end

  // next state and result for one character
  always_comb begin
    phase_d     = phase_q;
    kw_idx_d    = kw_idx_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    first_d     = first_q;
    op_d        = op_q;
    hi_d        = hi_q;
    bytes_d     = bytes_q;
    err_d       = err_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      if (item_i.end_of_text) begin
        // final result, then back to reset state
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_RESULT;
        res_o.status     = final_st;
        res_o.byte_count = bytes_q;
        if (final_st == ST_CALL) begin
          res_o.operand_a     = first_q;
          res_o.operator_code = op_q;
          res_o.operand_b     = signed_val;
        end
        phase_d  = PH_LEAD;
        kw_idx_d = '0;
        mag_d    = '0;
        neg_d    = 1'b0;
        first_d  = '0;
        op_d     = OP_ADD;
        hi_d     = '0;
        bytes_d  = '0;
        err_d    = ST_CALL;
      end else if (phase_q != PH_STOPPED) begin
        if (c == 8'h00) begin
          // nul ends the line early
          err_d   = final_st;
          phase_d = PH_STOPPED;
        end else begin
          case (phase_q)
            PH_LEAD: begin
              if (!ws) begin
                if (c == kw_char(3'd0)) begin
                  kw_idx_d = 3'd1;
                  phase_d  = PH_KEYWORD;
                end else begin
                  err_d   = ST_NOT_CALL;
                  phase_d = PH_STOPPED;
                end
              end
            end
            PH_KEYWORD: begin
              if (c == kw_char(kw_idx_q)) begin
                kw_idx_d = kw_idx_q + 3'd1;
                if (kw_idx_q == KW_LAST) phase_d = PH_KW_END;
              end else begin
                err_d   = ST_NOT_CALL;
                phase_d = PH_STOPPED;
              end
            end
            PH_KW_END: begin
              if (ws) begin
                phase_d = PH_A_PRE;
              end else begin
                err_d   = ST_NOT_CALL;
                phase_d = PH_STOPPED;
              end
            end
            PH_A_PRE, PH_B_PRE: begin
              // start of a number: sign or first digit
              if (!ws) begin
                mag_d = '0;
                neg_d = 1'b0;
                if ((c == "+") || (c == "-")) begin
                  neg_d   = (c == "-");
                  phase_d = (phase_q == PH_A_PRE) ? PH_A_SIGN : PH_B_SIGN;
                end else if (is_digit(c)) begin
                  mag_d   = {28'b0, digit};
                  phase_d = (phase_q == PH_A_PRE) ? PH_A_DIG : PH_B_DIG;
                end else begin
                  err_d   = ST_FORMAT;
                  phase_d = PH_STOPPED;
                end
              end
            end
            PH_A_SIGN, PH_A_DIG, PH_B_SIGN, PH_B_DIG: begin
              if (is_digit(c)) begin
                if (acc_ovf) begin
                  err_d   = ST_FORMAT;
                  phase_d = PH_STOPPED;
                end else begin
                  mag_d   = acc[31:0];
                  phase_d = ((phase_q == PH_A_SIGN) || (phase_q == PH_A_DIG)) ?
                            PH_A_DIG : PH_B_DIG;
                end
              end else if ((phase_q == PH_A_SIGN) || (phase_q == PH_B_SIGN)) begin
                err_d   = ST_FORMAT;
                phase_d = PH_STOPPED;
              end else if (phase_q == PH_A_DIG) begin
                // operand a complete, look for operator
                first_d = signed_val;
                if (ws) begin
                  phase_d = PH_OP_WAIT;
                end else if ((c == "+") || (c == "-") || (c == "*") || (c == "/")) begin
                  op_d    = (c == "+") ? OP_ADD : (c == "-") ? OP_SUB :
                            (c == "*") ? OP_MUL : OP_DIV;
                  mag_d   = '0;
                  neg_d   = 1'b0;
                  phase_d = PH_B_PRE;
                end else begin
                  err_d   = ST_FORMAT;
                  phase_d = PH_STOPPED;
                end
              end else begin
                // operand b complete, look for colon
                if (ws) begin
                  phase_d = PH_COLON;
                end else if (c == ":") begin
                  phase_d = PH_HEX_WAIT;
                end else begin
                  err_d   = ST_FORMAT;
                  phase_d = PH_STOPPED;
                end
              end
            end
            PH_OP_WAIT: begin
              if ((c == "+") || (c == "-") || (c == "*") || (c == "/")) begin
                op_d    = (c == "+") ? OP_ADD : (c == "-") ? OP_SUB :
                          (c == "*") ? OP_MUL : OP_DIV;
                mag_d   = '0;
                neg_d   = 1'b0;
                phase_d = PH_B_PRE;
              end else if (!ws) begin
                err_d   = ST_FORMAT;
                phase_d = PH_STOPPED;
              end
            end
            PH_COLON: begin
              if (c == ":") begin
                phase_d = PH_HEX_WAIT;
              end else if (!ws) begin
                err_d   = ST_FORMAT;
                phase_d = PH_STOPPED;
              end
            end
            PH_HEX_WAIT: begin
              if (!ws) begin
                if (hex.valid) begin
                  hi_d    = hex.value;
                  phase_d = PH_HEX_LO;
                end else begin
                  err_d   = ST_FORMAT;
                  phase_d = PH_STOPPED;
                end
              end
            end
            PH_HEX_LO: begin
              // second nibble completes a byte unless it is not a hex digit or capacity is reached
              if (!hex.valid || (bytes_q >= 7'(CODE_CAPACITY))) begin
                err_d   = ST_FORMAT;
                phase_d = PH_STOPPED;
              end else begin
                bytes_d          = bytes_q + 7'd1;
                phase_d          = PH_HEX_SEP;
                res_valid_o      = 1'b1;
                res_o.kind       = KIND_BYTE;
                res_o.byte_value = {hi_q, hex.value};
                res_o.byte_count = bytes_q + 7'd1;
              end
            end
            PH_HEX_SEP: begin
              if (ws) begin
                phase_d = PH_HEX_WAIT;
              end else begin
                err_d   = ST_FORMAT;
                phase_d = PH_STOPPED;
              end
            end
            default: begin
              err_d   = ST_FORMAT;
              phase_d = PH_STOPPED;
            end
          endcase
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      kw_idx_q <= '0;
      mag_q    <= '0;
      neg_q    <= 1'b0;
      first_q  <= '0;
      op_q     <= OP_ADD;
      hi_q     <= '0;
      bytes_q  <= '0;
      err_q    <= ST_CALL;
    end else begin
      phase_q  <= phase_d;
      kw_idx_q <= kw_idx_d;
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      first_q  <= first_d;
      op_q     <= op_d;
      hi_q     <= hi_d;
      bytes_q  <= bytes_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

/* sv/bytes_call_text_parser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Parser for a "/bytes A op B : hh hh ..." text line, fed one character per
// transfer and closed by an end-of-text transfer. Each character passes an
// input register, one pass of parse logic and a result register, in that
// order: one character per clock cycle sustained while out_stall_i is low.
// A result register that still waits on out_stall_i holds up the parser
// stage, and the input register then stalls the sender.
// Each completed hex pair gives a byte result as soon as it is decoded; the
// end-of-text transfer gives one final result (status, A, operator, B, byte
// count) and returns the parser to its reset state. Bytes are void unless the
// final status is a valid call.
module bytes_call_text_parser_unit import bcp_pkg::*; #(
  parameter int CODE_CAPACITY = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire bcp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output bcp_out_t      out_data_o
);

  logic     in_valid_q;
  bcp_in_t  in_q;
  logic     out_valid_q;
  bcp_out_t out_q;
  logic     step;
  logic     res_valid;
  bcp_out_t res;

  // the held character moves on when the result register is free or drains
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  bcp_parse_core #(
    .CODE_CAPACITY(CODE_CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
